[hdl/vpa_pkg.sv]
// ----------------------------------------------------------------------------
// vpa_pkg
// shared types, codes and defaults of the variable partition allocator
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int VPA_FREE_ENTRIES = 16;
  localparam int VPA_JOB_ENTRIES  = 16;
  localparam int VPA_ADDR_BITS    = 16;

  // command codes
  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_COMPACT = 2'd3
  } cmd_t;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_NOTRES  = 3'd2;
  localparam logic [2:0] ST_ALREADY = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_NOSPACE = 3'd5;

  // fit modes
  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;
  localparam logic [1:0] FIT_FIRST = 2'd2;
  localparam logic [1:0] FIT_LAST  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FIT_MODE = 2'd0;
  localparam logic [1:0] CFG_MEM_BASE = 2'd1;
  localparam logic [1:0] CFG_MEM_SIZE = 2'd2;

  localparam logic [1:0]  FIT_MODE_RESET = FIT_FIRST;
  localparam logic [15:0] MEM_BASE_RESET = 16'd0;
  localparam logic [15:0] MEM_SIZE_RESET = 16'hffff;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_JFIND,
    S_ACHK,
    S_FSCAN,
    S_AUPD,
    S_FDN_RD,
    S_FDN_WR,
    S_JPOS,
    S_JUP_RD,
    S_JUP_WR,
    S_JWR,
    S_RCHK,
    S_RPOS,
    S_RUPD,
    S_FUP_RD,
    S_FUP_WR,
    S_FWR,
    S_JDN_RD,
    S_JDN_WR,
    S_CSTART,
    S_CRD,
    S_CWR,
    S_CFIN,
    S_EMIT
  } state_t;

endpackage

[hdl/vpa_ram.sv]
// ----------------------------------------------------------------------------
// vpa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module vpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/variable_partition_allocator_unit.sv]
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// variable partition allocator: address-ordered free and job tables in rams,
// served by a sequencer for init, allocate, release and compact
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | cmd, job_id, request_size
//  result   | out_valid / out_stall| status, start_address, out_job_id, last
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one command at a time; the cost of allocate and release grows with the
//  free entries in use and the resident jobs, and that of compact with the
//  resident jobs; the cost comes from scans and entry shifts over the two
//  ram read ports
//  reset clears the counts and the controller; table contents stay undefined
//  a stalled result holds the sequencer in its emit step; the result register
//  lets the next command enter while the final beat still waits
// ----------------------------------------------------------------------------
module variable_partition_allocator_unit
  import vpa_pkg::*;
#(
  parameter int FREE_ENTRIES = VPA_FREE_ENTRIES,
  parameter int JOB_ENTRIES  = VPA_JOB_ENTRIES,
  parameter int ADDR_BITS    = VPA_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  job_id,
  input  logic [15:0] request_size,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] start_address,
  output logic [7:0]  out_job_id,
  output logic        last,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // lengths and starts may reach the top of the address space itself
  localparam int W        = ADDR_BITS + 1;
  localparam int CMP_BITS = (W > 16) ? W : 16;
  localparam int FI       = $clog2(FREE_ENTRIES);
  localparam int FC       = $clog2(FREE_ENTRIES + 1);
  localparam int JI       = $clog2(JOB_ENTRIES);
  localparam int JC       = $clog2(JOB_ENTRIES + 1);
  localparam int FREE_W   = 2 * W;
  localparam int JOB_W    = 8 + 2 * W;

  // control state
  state_t         state, state_next;
  state_t         em_ret, em_ret_next;
  logic [1:0]     fit_mode;
  logic [15:0]    mem_base, mem_size;
  logic [FC-1:0]  free_count, free_count_next;
  logic [JC-1:0]  job_count, job_count_next;
  logic           rd_vld, rd_vld_next;
  logic           found, found_next;
  logic           pv, pv_next;
  logic           pos_f, pos_f_next;

  // working registers
  logic [W-1:0]   region_base, region_base_next;
  logic [W-1:0]   region_len, region_len_next;
  cmd_t           cmd_r, cmd_r_next;
  logic [7:0]     id_r, id_r_next;
  logic [15:0]    size_r, size_r_next;
  logic [FC-1:0]  fk, fk_next;
  logic [JC-1:0]  jk, jk_next;
  logic [JC-1:0]  fidx, fidx_next;
  logic [W-1:0]   js, js_next, jl, jl_next;
  logic [FC-1:0]  pick, pick_next;
  logic [W-1:0]   ps, ps_next, pl, pl_next;
  logic [FC-1:0]  fpos, fpos_next;
  logic [JC-1:0]  jpos, jpos_next;
  logic [W-1:0]   bl_s, bl_s_next, bl_l, bl_l_next;
  logic [W-1:0]   ab_s, ab_s_next, ab_l, ab_l_next;
  logic [W-1:0]   acc, acc_next;
  logic [2:0]     em_status, em_status_next;
  logic [W-1:0]   em_start, em_start_next;
  logic [7:0]     em_id, em_id_next;
  logic           em_last, em_last_next;

  // ram ports
  logic              f_we, j_we;
  logic [FI-1:0]     f_waddr, f_raddr;
  logic [JI-1:0]     j_waddr, j_raddr;
  logic [FREE_W-1:0] f_wdata, f_rdata;
  logic [JOB_W-1:0]  j_wdata, j_rdata;

  vpa_ram #(.WIDTH(FREE_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  vpa_ram #(.WIDTH(JOB_W), .DEPTH(JOB_ENTRIES)) u_job_ram (
    .clk   (clk),
    .we    (j_we),
    .waddr (j_waddr),
    .wdata (j_wdata),
    .raddr (j_raddr),
    .rdata (j_rdata)
  );

  // ram read fields
  logic [W-1:0] f_rd_s, f_rd_l, j_rd_s, j_rd_l;
  logic [7:0]   j_rd_tag;
  assign f_rd_s   = f_rdata[2*W-1:W];
  assign f_rd_l   = f_rdata[W-1:0];
  assign j_rd_tag = j_rdata[JOB_W-1:2*W];
  assign j_rd_s   = j_rdata[2*W-1:W];
  assign j_rd_l   = j_rdata[W-1:0];

  // index arithmetic
  logic [FC-1:0] fk_p1, fk_m1, fpos_m1;
  logic [JC-1:0] jk_p1, jk_m1;
  assign fk_p1   = fk + FC'(1);
  assign fk_m1   = fk - FC'(1);
  assign fpos_m1 = fpos - FC'(1);
  assign jk_p1   = jk + JC'(1);
  assign jk_m1   = jk - JC'(1);

  // scan control: one read issued per cycle, its data processed in the next cycle
  logic f_issue, j_issue, f_scan_done, j_scan_done;
  assign f_issue     = fk < free_count;
  assign j_issue     = jk < job_count;
  assign f_scan_done = !f_issue && !rd_vld;
  assign j_scan_done = !j_issue && !rd_vld;

  // request size in table width
  logic [CMP_BITS-1:0] size_c;
  logic [W-1:0]        size_w;
  assign size_c = CMP_BITS'(size_r);
  assign size_w = W'(size_c);

  // region latch at init: base masked, length clipped at the address top
  logic [CMP_BITS-1:0] limit_c, b_c, avail_c, l_c;
  logic [W-1:0]        init_b, init_l;
  assign limit_c = CMP_BITS'(1) << ADDR_BITS;
  assign b_c     = CMP_BITS'(mem_base) & (limit_c - CMP_BITS'(1));
  assign avail_c = limit_c - b_c;
  assign l_c     = (CMP_BITS'(mem_size) > avail_c) ? avail_c : CMP_BITS'(mem_size);
  assign init_b  = W'(b_c);
  assign init_l  = W'(l_c);

  // fit decisions on the entry that just came back
  logic f_fits, f_take;
  assign f_fits = CMP_BITS'(f_rd_l) >= size_c;
  assign f_take = !pv
               || (fit_mode == FIT_BEST  && f_rd_l < pl)
               || (fit_mode == FIT_WORST && f_rd_l > pl)
               || (fit_mode == FIT_LAST);

  logic a_pass, a_split;
  assign a_pass  = !found && (job_count != JC'(JOB_ENTRIES))
                && (free_count != '0) && (size_r != '0);
  assign a_split = CMP_BITS'(pl) > size_c;

  // coalescing of a released region with its neighbours
  logic [W-1:0] bl_end, js_end;
  logic         below, above;
  assign bl_end = bl_s + bl_l;
  assign js_end = js + jl;
  assign below  = (fpos != '0) && (bl_end == js);
  assign above  = pos_f && (js_end == ab_s);

  logic in_fire, out_free, out_load;
  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_EMIT) && out_free;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(cmd))
            CMD_INIT:    state_next = S_INIT;
            CMD_ALLOC:   state_next = S_JFIND;
            CMD_RELEASE: state_next = S_JFIND;
            CMD_COMPACT: state_next = S_CSTART;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_INIT:   state_next = S_EMIT;
      S_JFIND: begin
        if (j_scan_done) state_next = (cmd_r == CMD_ALLOC) ? S_ACHK : S_RCHK;
      end
      S_ACHK:   state_next = a_pass ? S_FSCAN : S_EMIT;
      S_FSCAN: begin
        if (f_scan_done) state_next = S_AUPD;
      end
      S_AUPD: begin
        if (!pv)          state_next = S_EMIT;
        else if (a_split) state_next = S_JPOS;
        else              state_next = S_FDN_RD;
      end
      S_FDN_RD: begin
        if (fk_p1 < free_count)      state_next = S_FDN_WR;
        else if (cmd_r == CMD_ALLOC) state_next = S_JPOS;
        else                         state_next = S_JDN_RD;
      end
      S_FDN_WR: state_next = S_FDN_RD;
      S_JPOS: begin
        if (j_scan_done) state_next = S_JUP_RD;
      end
      S_JUP_RD: state_next = (jk > jpos) ? S_JUP_WR : S_JWR;
      S_JUP_WR: state_next = S_JUP_RD;
      S_JWR:    state_next = S_EMIT;
      S_RCHK:   state_next = found ? S_RPOS : S_EMIT;
      S_RPOS: begin
        if (f_scan_done) state_next = S_RUPD;
      end
      S_RUPD: begin
        if (below && above)                           state_next = S_FDN_RD;
        else if (below || above)                      state_next = S_JDN_RD;
        else if (free_count == FC'(FREE_ENTRIES))     state_next = S_EMIT;
        else                                          state_next = S_FUP_RD;
      end
      S_FUP_RD: state_next = (fk > fpos) ? S_FUP_WR : S_FWR;
      S_FUP_WR: state_next = S_FUP_RD;
      S_FWR:    state_next = S_JDN_RD;
      S_JDN_RD: state_next = (jk_p1 < job_count) ? S_JDN_WR : S_EMIT;
      S_JDN_WR: state_next = S_JDN_RD;
      S_CSTART: state_next = (free_count == '0) ? S_EMIT : S_CRD;
      S_CRD:    state_next = j_issue ? S_CWR : S_CFIN;
      S_CWR:    state_next = S_EMIT;
      S_CFIN:   state_next = (job_count == '0) ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_free) state_next = em_ret;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and ram control
  // --------------------------------------------------------------------------
  always_comb begin
    free_count_next  = free_count;
    job_count_next   = job_count;
    region_base_next = region_base;
    region_len_next  = region_len;
    cmd_r_next       = cmd_r;
    id_r_next        = id_r;
    size_r_next      = size_r;
    fk_next          = fk;
    jk_next          = jk;
    fidx_next        = fidx;
    found_next       = found;
    js_next          = js;
    jl_next          = jl;
    pv_next          = pv;
    pick_next        = pick;
    ps_next          = ps;
    pl_next          = pl;
    pos_f_next       = pos_f;
    fpos_next        = fpos;
    jpos_next        = jpos;
    bl_s_next        = bl_s;
    bl_l_next        = bl_l;
    ab_s_next        = ab_s;
    ab_l_next        = ab_l;
    acc_next         = acc;
    em_status_next   = em_status;
    em_start_next    = em_start;
    em_id_next       = em_id;
    em_last_next     = em_last;
    em_ret_next      = em_ret;
    rd_vld_next      = 1'b0;
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    f_raddr = '0;
    j_we    = 1'b0;
    j_waddr = '0;
    j_wdata = '0;
    j_raddr = '0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd_r_next  = cmd_t'(cmd);
          id_r_next   = job_id;
          size_r_next = request_size;
          jk_next     = '0;
          found_next  = 1'b0;
        end
      end

      S_INIT: begin
        region_base_next = init_b;
        region_len_next  = init_l;
        job_count_next   = '0;
        em_start_next    = init_b;
        em_id_next       = '0;
        em_last_next     = 1'b1;
        em_ret_next      = S_IDLE;
        if (init_l == '0) begin
          free_count_next = '0;
          em_status_next  = ST_NOSPACE;
        end else begin
          f_we            = 1'b1;
          f_waddr         = '0;
          f_wdata         = {init_b, init_l};
          free_count_next = FC'(1);
          em_status_next  = ST_OK;
        end
      end

      // look the job id up in the job table
      S_JFIND: begin
        if (j_issue) begin
          j_raddr = jk[JI-1:0];
          jk_next = jk_p1;
        end
        rd_vld_next = j_issue;
        if (rd_vld && !found && j_rd_tag == id_r) begin
          found_next = 1'b1;
          fidx_next  = jk_m1;
          js_next    = j_rd_s;
          jl_next    = j_rd_l;
        end
      end

      S_ACHK: begin
        em_start_next = '0;
        em_id_next    = id_r;
        em_last_next  = 1'b1;
        em_ret_next   = S_IDLE;
        fk_next       = '0;
        pv_next       = 1'b0;
        if (found)                                em_status_next = ST_ALREADY;
        else if (job_count == JC'(JOB_ENTRIES))   em_status_next = ST_FULL;
        else if (free_count == '0)                em_status_next = ST_NOSPACE;
        else                                      em_status_next = ST_NOFIT;
      end

      // pick a free segment by the fit mode; best and worst fit break ties to the lowest address
      S_FSCAN: begin
        if (f_issue) begin
          f_raddr = fk[FI-1:0];
          fk_next = fk_p1;
        end
        rd_vld_next = f_issue;
        if (rd_vld && f_fits && f_take) begin
          pv_next   = 1'b1;
          pick_next = fk_m1;
          ps_next   = f_rd_s;
          pl_next   = f_rd_l;
        end
      end

      S_AUPD: begin
        em_status_next = ST_NOFIT;
        em_start_next  = '0;
        em_id_next     = id_r;
        em_last_next   = 1'b1;
        em_ret_next    = S_IDLE;
        jk_next        = '0;
        pos_f_next     = 1'b0;
        fk_next        = pick;
        if (pv && a_split) begin
          f_we    = 1'b1;
          f_waddr = pick[FI-1:0];
          f_wdata = {ps + size_w, pl - size_w};
        end
      end

      // remove free entry fk by shifting the upper ones down
      S_FDN_RD: begin
        if (fk_p1 < free_count) begin
          f_raddr = fk_p1[FI-1:0];
        end else begin
          free_count_next = free_count - FC'(1);
          jk_next         = (cmd_r == CMD_ALLOC) ? '0 : fidx;
          pos_f_next      = 1'b0;
        end
      end
      S_FDN_WR: begin
        f_we    = 1'b1;
        f_waddr = fk[FI-1:0];
        f_wdata = f_rdata;
        fk_next = fk_p1;
      end

      // insert point in the job table: first start not below the new one
      S_JPOS: begin
        if (j_issue) begin
          j_raddr = jk[JI-1:0];
          jk_next = jk_p1;
        end
        rd_vld_next = j_issue;
        if (rd_vld && !pos_f && j_rd_s >= ps) begin
          pos_f_next = 1'b1;
          jpos_next  = jk_m1;
        end
        if (j_scan_done) begin
          jk_next = job_count;
          if (!pos_f) jpos_next = job_count;
        end
      end
      S_JUP_RD: begin
        if (jk > jpos) j_raddr = jk_m1[JI-1:0];
      end
      S_JUP_WR: begin
        j_we    = 1'b1;
        j_waddr = jk[JI-1:0];
        j_wdata = j_rdata;
        jk_next = jk_m1;
      end
      S_JWR: begin
        j_we           = 1'b1;
        j_waddr        = jpos[JI-1:0];
        j_wdata        = {id_r, ps, size_w};
        job_count_next = job_count + JC'(1);
        em_status_next = ST_OK;
        em_start_next  = ps;
        em_id_next     = id_r;
        em_last_next   = 1'b1;
        em_ret_next    = S_IDLE;
      end

      S_RCHK: begin
        em_status_next = ST_NOTRES;
        em_start_next  = '0;
        em_id_next     = id_r;
        em_last_next   = 1'b1;
        em_ret_next    = S_IDLE;
        fk_next        = '0;
        pos_f_next     = 1'b0;
      end

      // find the free neighbours of the released region
      S_RPOS: begin
        if (f_issue) begin
          f_raddr = fk[FI-1:0];
          fk_next = fk_p1;
        end
        rd_vld_next = f_issue;
        if (rd_vld && !pos_f) begin
          if (f_rd_s >= js) begin
            pos_f_next = 1'b1;
            fpos_next  = fk_m1;
            ab_s_next  = f_rd_s;
            ab_l_next  = f_rd_l;
          end else begin
            bl_s_next = f_rd_s;
            bl_l_next = f_rd_l;
          end
        end
        if (f_scan_done && !pos_f) fpos_next = free_count;
      end

      S_RUPD: begin
        em_status_next = ST_FULL;
        em_start_next  = '0;
        em_id_next     = id_r;
        em_last_next   = 1'b1;
        em_ret_next    = S_IDLE;
        jk_next        = fidx;
        fk_next        = free_count;
        if (below && above) begin
          f_we    = 1'b1;
          f_waddr = fpos_m1[FI-1:0];
          f_wdata = {bl_s, bl_l + jl + ab_l};
          fk_next = fpos;
        end else if (below) begin
          f_we    = 1'b1;
          f_waddr = fpos_m1[FI-1:0];
          f_wdata = {bl_s, bl_l + jl};
        end else if (above) begin
          f_we    = 1'b1;
          f_waddr = fpos[FI-1:0];
          f_wdata = {js, ab_l + jl};
        end
      end

      // open a gap at fpos in the free table
      S_FUP_RD: begin
        if (fk > fpos) f_raddr = fk_m1[FI-1:0];
      end
      S_FUP_WR: begin
        f_we    = 1'b1;
        f_waddr = fk[FI-1:0];
        f_wdata = f_rdata;
        fk_next = fk_m1;
      end
      S_FWR: begin
        f_we            = 1'b1;
        f_waddr         = fpos[FI-1:0];
        f_wdata         = {js, jl};
        free_count_next = free_count + FC'(1);
        jk_next         = fidx;
      end

      // drop job entry jk
      S_JDN_RD: begin
        if (jk_p1 < job_count) begin
          j_raddr = jk_p1[JI-1:0];
        end else begin
          job_count_next = job_count - JC'(1);
          em_status_next = ST_OK;
          em_start_next  = js;
          em_id_next     = id_r;
          em_last_next   = 1'b1;
          em_ret_next    = S_IDLE;
        end
      end
      S_JDN_WR: begin
        j_we    = 1'b1;
        j_waddr = jk[JI-1:0];
        j_wdata = j_rdata;
        jk_next = jk_p1;
      end

      // compaction: pack jobs upward from the region base
      S_CSTART: begin
        em_status_next = ST_NOSPACE;
        em_start_next  = '0;
        em_id_next     = '0;
        em_last_next   = 1'b1;
        em_ret_next    = S_IDLE;
        acc_next       = region_base;
        jk_next        = '0;
      end
      S_CRD: begin
        if (j_issue) j_raddr = jk[JI-1:0];
      end
      S_CWR: begin
        j_we           = 1'b1;
        j_waddr        = jk[JI-1:0];
        j_wdata        = {j_rd_tag, acc, j_rd_l};
        em_status_next = ST_OK;
        em_start_next  = acc;
        em_id_next     = j_rd_tag;
        em_last_next   = (jk_p1 == job_count);
        em_ret_next    = S_CRD;
        acc_next       = acc + j_rd_l;
        jk_next        = jk_p1;
      end
      S_CFIN: begin
        f_we            = 1'b1;
        f_waddr         = '0;
        f_wdata         = {acc, region_len - (acc - region_base)};
        free_count_next = FC'(1);
        em_status_next  = ST_OK;
        em_start_next   = acc;
        em_id_next      = '0;
        em_last_next    = 1'b1;
        em_ret_next     = S_IDLE;
      end

      S_EMIT: begin
      end

      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      em_ret     <= S_IDLE;
      free_count <= '0;
      job_count  <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      pv         <= 1'b0;
      pos_f      <= 1'b0;
      region_base <= '0;
      region_len  <= '0;
    end else begin
      state      <= state_next;
      em_ret     <= em_ret_next;
      free_count <= free_count_next;
      job_count  <= job_count_next;
      rd_vld     <= rd_vld_next;
      found      <= found_next;
      pv         <= pv_next;
      pos_f      <= pos_f_next;
      region_base <= region_base_next;
      region_len  <= region_len_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_r_next;
    id_r      <= id_r_next;
    size_r    <= size_r_next;
    fk        <= fk_next;
    jk        <= jk_next;
    fidx      <= fidx_next;
    js        <= js_next;
    jl        <= jl_next;
    pick      <= pick_next;
    ps        <= ps_next;
    pl        <= pl_next;
    fpos      <= fpos_next;
    jpos      <= jpos_next;
    bl_s      <= bl_s_next;
    bl_l      <= bl_l_next;
    ab_s      <= ab_s_next;
    ab_l      <= ab_l_next;
    acc       <= acc_next;
    em_status <= em_status_next;
    em_start  <= em_start_next;
    em_id     <= em_id_next;
    em_last   <= em_last_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= FIT_MODE_RESET;
      mem_base <= MEM_BASE_RESET;
      mem_size <= MEM_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIT_MODE: fit_mode <= cfg_data[1:0];
        CFG_MEM_BASE: mem_base <= cfg_data;
        CFG_MEM_SIZE: mem_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result register: one beat at a time
  logic [CMP_BITS-1:0] em_start_ext;
  assign em_start_ext = CMP_BITS'(em_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= em_status;
      start_address <= em_start_ext[15:0];
      out_job_id    <= em_id;
      last          <= em_last;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while not stalling afterwards");

  a_free_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FC'(FREE_ENTRIES))
    else $error("free count beyond table depth");

  a_job_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= JC'(JOB_ENTRIES))
    else $error("job count beyond table depth");

  a_multi_beat_compact: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && em_ret == S_CRD |-> cmd_r == CMD_COMPACT)
    else $error("relocation beat outside compaction");

endmodule

[test/vpa_checker.sv]
// ----------------------------------------------------------------------------
// vpa_checker
// watches the command, result and config channels of the allocator, keeps a
// private copy of the free and job tables, and checks every result beat
// ----------------------------------------------------------------------------
module vpa_checker
  import vpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  job_id,
  input  logic [15:0] request_size,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [15:0] start_address,
  input  logic [7:0]  out_job_id,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = VPA_FREE_ENTRIES;
  localparam int NJ = VPA_JOB_ENTRIES;

  typedef struct packed {
    logic [2:0]  st;
    logic [15:0] addr;
    logic [7:0]  id;
    logic        fin;
  } beat_t;

  beat_t due_results[$];

  logic [1:0]  fit;
  logic [15:0] base_reg, size_reg;
  int seg_start[NF], seg_len[NF], seg_cnt;
  int res_tag[NJ], res_start[NJ], res_len[NJ], res_cnt;
  int region_lo, region_len;

  function automatic void push(logic [2:0] st, int addr, int id, bit fin);
    beat_t b;
    b.st = st; b.addr = addr[15:0]; b.id = id[7:0]; b.fin = fin;
    due_results.push_back(b);
  endfunction

  function automatic void seg_drop(int i);
    for (int k = i; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k+1]; seg_len[k] = seg_len[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic void res_drop(int i);
    for (int k = i; k + 1 < res_cnt; k++) begin
      res_tag[k] = res_tag[k+1]; res_start[k] = res_start[k+1]; res_len[k] = res_len[k+1];
    end
    res_cnt--;
  endfunction

  function automatic int res_find(int id);
    for (int i = 0; i < res_cnt; i++) if (res_tag[i] == id) return i;
    return -1;
  endfunction

  // expected beats for one accepted command
  function automatic void plan_command(cmd_t c, int id, int sz);
    int pick, s, l, i, a;
    bit below, above;
    case (c)
      CMD_INIT: begin
        region_lo = base_reg;
        region_len = size_reg;
        if (region_len > 65536 - region_lo) region_len = 65536 - region_lo;
        res_cnt = 0;
        seg_cnt = 0;
        if (region_len == 0) push(ST_NOSPACE, region_lo, 0, 1);
        else begin
          seg_start[0] = region_lo; seg_len[0] = region_len; seg_cnt = 1;
          push(ST_OK, region_lo, 0, 1);
        end
      end
      CMD_ALLOC: begin
        pick = -1;
        if (res_find(id) >= 0) push(ST_ALREADY, 0, id, 1);
        else if (res_cnt >= NJ) push(ST_FULL, 0, id, 1);
        else if (seg_cnt == 0) push(ST_NOSPACE, 0, id, 1);
        else if (sz == 0) push(ST_NOFIT, 0, id, 1);
        else begin
          for (i = 0; i < seg_cnt; i++) begin
            if (seg_len[i] < sz) continue;
            if (pick < 0) begin
              pick = i;
              if (fit == FIT_FIRST) break;
            end else if (fit == FIT_BEST && seg_len[i] < seg_len[pick]) pick = i;
            else if (fit == FIT_WORST && seg_len[i] > seg_len[pick]) pick = i;
            else if (fit == FIT_LAST) pick = i;
          end
          if (pick < 0) push(ST_NOFIT, 0, id, 1);
          else begin
            s = seg_start[pick];
            if (seg_len[pick] > sz) begin
              seg_start[pick] += sz; seg_len[pick] -= sz;
            end else seg_drop(pick);
            i = 0;
            while (i < res_cnt && res_start[i] < s) i++;
            for (int k = res_cnt; k > i; k--) begin
              res_tag[k] = res_tag[k-1]; res_start[k] = res_start[k-1]; res_len[k] = res_len[k-1];
            end
            res_tag[i] = id; res_start[i] = s; res_len[i] = sz;
            res_cnt++;
            push(ST_OK, s, id, 1);
          end
        end
      end
      CMD_RELEASE: begin
        pick = res_find(id);
        if (pick < 0) push(ST_NOTRES, 0, id, 1);
        else begin
          s = res_start[pick]; l = res_len[pick];
          i = 0;
          while (i < seg_cnt && seg_start[i] < s) i++;
          below = i > 0 && seg_start[i-1] + seg_len[i-1] == s;
          above = i < seg_cnt && s + l == seg_start[i];
          if (!below && !above && seg_cnt >= NF) push(ST_FULL, 0, id, 1);
          else begin
            if (below && above) begin
              seg_len[i-1] += l + seg_len[i];
              seg_drop(i);
            end else if (below) seg_len[i-1] += l;
            else if (above) begin
              seg_start[i] = s; seg_len[i] += l;
            end else begin
              for (int k = seg_cnt; k > i; k--) begin
                seg_start[k] = seg_start[k-1]; seg_len[k] = seg_len[k-1];
              end
              seg_start[i] = s; seg_len[i] = l;
              seg_cnt++;
            end
            res_drop(pick);
            push(ST_OK, s, id, 1);
          end
        end
      end
      default: begin
        if (seg_cnt == 0) push(ST_NOSPACE, 0, 0, 1);
        else begin
          a = region_lo;
          for (i = 0; i < res_cnt; i++) begin
            res_start[i] = a;
            a += res_len[i];
            push(ST_OK, res_start[i], res_tag[i], i + 1 == res_cnt);
          end
          seg_start[0] = a;
          seg_len[0] = region_len - (a - region_lo);
          seg_cnt = 1;
          if (res_cnt == 0) push(ST_OK, a, 0, 1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      fit <= FIT_MODE_RESET;
      base_reg <= MEM_BASE_RESET;
      size_reg <= MEM_SIZE_RESET;
      seg_cnt = 0;
      res_cnt = 0;
      region_lo = 0;
      region_len = 0;
      due_results.delete();
      mismatches <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result beat st=%0d addr=%0d id=%0d last=%0b",
                     $realtime, status, start_address, out_job_id, last);
          mismatches <= mismatches + 1;
        end else begin
          want = due_results.pop_front();
          if (want != {status, start_address, out_job_id, last}) begin
            if (mismatches < 10)
              $display("%0t: result mismatch exp st=%0d addr=%0d id=%0d last=%0b, got st=%0d addr=%0d id=%0d last=%0b",
                       $realtime, want.st, want.addr, want.id, want.fin,
                       status, start_address, out_job_id, last);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        plan_command(cmd_t'(cmd), job_id, request_size);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIT_MODE) fit <= cfg_data[1:0];
        else if (cfg_index == CFG_MEM_BASE) base_reg <= cfg_data;
        else if (cfg_index == CFG_MEM_SIZE) size_reg <= cfg_data;
      end
    end
  end

  assign outstanding = due_results.size();

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the variable partition allocator: directed corner commands,
// then random allocate/release/compact/init traffic under several fit modes and
// regions, with random gaps and stalls; vpa_checker judges every beat
// ----------------------------------------------------------------------------
module tb_top;
  import vpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_INIT;
  logic [7:0]  job_id = '0;
  logic [15:0] request_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] start_address;
  logic [7:0]  out_job_id;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_FIT_MODE;
  logic [15:0] cfg_data = '0;

  int mismatches, outstanding;
  int cycles = 0;
  bit quiet = 0;          // phase with no gaps and no stalls
  int hold_asks = 0;      // long receiver hold-offs requested so far
  int region_size = 65535;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 150;   // worst case command latency with some margin

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  variable_partition_allocator_unit DUT (.*);

  vpa_checker u_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("variable_partition_allocator_unit verification failed");
      $finish;
    end
  end

  // result side: random stall runs, plus long hold-offs on request
  initial begin : receiver
    int run_left, hold_done, hold_left;
    run_left = 0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_done != hold_asks) begin
        hold_done++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        out_stall = ($urandom_range(0, 2) == 0);
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // one command beat; entered and left at a falling edge
  task automatic send(cmd_t c, int id, int sz);
    int g;
    in_valid = 1'b1;
    cmd = c;
    job_id = id[7:0];
    request_size = sz[15:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // quiet point: only called with the command channel idle
  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[15:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup_region(logic [1:0] mode, int lo, int sz);
    drain();
    write_reg(CFG_FIT_MODE, mode);
    write_reg(CFG_MEM_BASE, lo);
    write_reg(CFG_MEM_SIZE, sz);
    region_size = sz;
    send(CMD_INIT, 0, 0);
  endtask

  // mostly well-formed traffic over a small id pool, some noise
  task automatic random_burst(int n);
    int r, sz, lim;
    lim = (region_size / 6 > 1) ? region_size / 6 : 1;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      sz = $urandom_range(1, lim);
      if (r < 45) send(CMD_ALLOC, $urandom_range(1, 20), sz);
      else if (r < 80) send(CMD_RELEASE, $urandom_range(1, 20), $urandom);
      else if (r < 88) send(CMD_COMPACT, $urandom, $urandom);
      else if (r < 91) send(CMD_INIT, $urandom, $urandom);
      else if (r < 96) send(CMD_ALLOC, $urandom_range(0, 255), $urandom_range(0, 65535));
      else send(CMD_RELEASE, $urandom_range(0, 255), $urandom_range(0, 65535));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // commands before any init
    send(CMD_ALLOC, 1, 10);
    send(CMD_RELEASE, 1, 0);
    send(CMD_COMPACT, 0, 0);

    // empty region
    drain();
    write_reg(CFG_MEM_SIZE, 0);
    region_size = 0;
    send(CMD_INIT, 0, 0);
    send(CMD_ALLOC, 255, 65535);

    // small region, first fit, one of each special case
    setup_region(FIT_FIRST, 16, 200);
    send(CMD_ALLOC, 1, 0);          // zero request
    send(CMD_ALLOC, 1, 50);
    send(CMD_ALLOC, 1, 20);         // already resident
    send(CMD_ALLOC, 0, 10);         // job id zero
    send(CMD_ALLOC, 2, 65535);      // no segment large enough
    send(CMD_ALLOC, 3, 40);
    send(CMD_RELEASE, 1, 0);        // opens a hole at the base
    send(CMD_RELEASE, 9, 0);        // not resident
    send(CMD_COMPACT, 0, 0);
    send(CMD_ALLOC, 4, 150);        // takes the remainder exactly
    send(CMD_COMPACT, 0, 0);        // no free segment left, so compact reports no space
    send(CMD_RELEASE, 0, 0);

    // region clipped at the top of the address space
    setup_region(FIT_WORST, 65535, 65535);
    send(CMD_ALLOC, 170, 1);
    send(CMD_ALLOC, 85, 1);

    setup_region(FIT_BEST, 65000, 65535);
    random_burst(20);

    // long receiver hold-off while commands keep coming
    hold_asks = 1;
    random_burst(10);

    setup_region(FIT_LAST, 0, 65535);
    random_burst(10);
    // sender pauses until everything has come back
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    random_burst(10);

    setup_region(FIT_FIRST, $urandom_range(0, 65535), $urandom_range(1, 65535));
    random_burst(15);

    quiet = 1;
    setup_region(FIT_BEST, 4660, 1000);
    random_burst(15);
    quiet = 0;

    setup_region(FIT_WORST, 43690, 21845);
    random_burst(5);

    setup_region(FIT_LAST, 0, 1);
    random_burst(5);

    drain();
    if (mismatches == 0) begin
      $display("variable_partition_allocator_unit verification clean");
    end else begin
      $display("variable_partition_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
